### rtl/mcl_pkg.sv
// mcl_pkg: shared types and constants of the mru command list
// command and response word layouts, command codes, list defaults
// no dependencies
`timescale 1ns / 1ps

package mcl_pkg;

	localparam int LIST_DEPTH_DEF = 32;
	localparam logic [5:0] MAX_ENTRIES_RST = 6'd20;

	localparam logic [1:0] CMD_ADD  = 2'd0;
	localparam logic [1:0] CMD_FIND = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] cmd_id;
		logic [31:0] name_tag;
		logic [4:0]  read_index;
	} cmd_word_t;

	typedef struct packed {
		logic        found;
		logic [15:0] out_id;
		logic [31:0] out_name;
		logic [5:0]  entry_count;
		logic        previous_valid;
		logic [15:0] previous_id;
	} rsp_word_t;

	typedef struct packed {
		logic        any;
		logic [15:0] sel_id;
		logic [31:0] sel_name;
	} pick_t;

endpackage

### rtl/mcl_cell.sv
// mcl_cell: one list position holding a command id and a name tag
// registers its own match for the accepted word, loads from its neighbor on a shift
// depends on mcl_pkg
`timescale 1ns / 1ps

module mcl_cell import mcl_pkg::*; #(
	parameter int INDEX = 0,
	parameter int LEN_W = 6
) (
	input  logic             clk,
	input  logic             capture,
	input  cmd_word_t        word,
	input  logic [LEN_W-1:0] length,
	input  logic             load,
	input  logic [15:0]      din_id,
	input  logic [31:0]      din_name,
	output logic             hit,
	output logic [15:0]      id,
	output logic [31:0]      name
);

	logic [15:0] id_q;
	logic [31:0] name_q;
	logic        hit_q;
	logic        live;
	logic        match;

	assign live = LEN_W'(INDEX) < length;

	always_comb begin
		unique case (word.command)
			CMD_ADD:  match = live && (id_q == word.cmd_id);
			CMD_FIND: match = live && (name_q == word.name_tag);
			CMD_READ: match = live && (32'(word.read_index) == 32'(INDEX));
			default:  match = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			hit_q <= match;
		end
		if (load) begin
			id_q   <= din_id;
			name_q <= din_name;
		end
	end

	assign hit  = hit_q;
	assign id   = id_q;
	assign name = name_q;

endmodule

### rtl/mcl_pick.sv
// mcl_pick: first-hit search across the cell row
// log-depth prefix of hit bits, shift mask for a moved entry, hit entry select
// depends on mcl_pkg
`timescale 1ns / 1ps

module mcl_pick import mcl_pkg::*; #(
	parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
	input  logic [LIST_DEPTH-1:0] hit,
	input  logic [15:0]           ids   [LIST_DEPTH],
	input  logic [31:0]           names [LIST_DEPTH],
	output logic [LIST_DEPTH-1:0] upto,
	output pick_t                 pick
);

	localparam int LVL = $clog2(LIST_DEPTH);

	logic [LIST_DEPTH-1:0] pre [0:LVL];
	logic [LIST_DEPTH-1:0] first;

	assign pre[0] = hit;

	for (genvar l = 0; l < LVL; l++) begin : g_lvl
		for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_bit
			if (k >= (1 << l)) begin : g_or
				assign pre[l+1][k] = pre[l][k] | pre[l][k - (1 << l)];
			end else begin : g_pass
				assign pre[l+1][k] = pre[l][k];
			end
		end
	end

	// position k is at or before the hit when nothing hit ahead of it
	for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_first
		if (k == 0) begin : g_head
			assign first[k] = hit[k];
			assign upto[k]  = pre[LVL][LIST_DEPTH-1];
		end else begin : g_rest
			assign first[k] = hit[k] & ~pre[LVL][k-1];
			assign upto[k]  = pre[LVL][LIST_DEPTH-1] & ~pre[LVL][k-1];
		end
	end

	always_comb begin
		pick.any      = pre[LVL][LIST_DEPTH-1];
		pick.sel_id   = '0;
		pick.sel_name = '0;
		for (int k = 0; k < LIST_DEPTH; k++) begin
			pick.sel_id   = pick.sel_id | ({16{first[k]}} & ids[k]);
			pick.sel_name = pick.sel_name | ({32{first[k]}} & names[k]);
		end
	end

endmodule

### rtl/mru_command_list_core.sv
// Most-recently-used command list. A command word is handled in steps: in the first
// every cell of the row compares its entry with the word and registers a hit bit,
// in the second the first hit is picked, the row shifts toward the back on an add
// and the response word is registered. The next command word is taken in the cycle
// after the second step, so the block takes no new command word while one is in hand;
// a response held by stall holds only the second step.
// Entries need no clearing after reset; the list length starts at zero.
`timescale 1ns / 1ps

module mru_command_list_core import mcl_pkg::*; #(
	parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [5:0] cfg_data,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_word_t cmd_word,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp_word
);

	localparam int LEN_W = $clog2(LIST_DEPTH + 1);
	localparam int CMP_W = (LEN_W > 6) ? LEN_W : 6;

	logic [5:0]       max_q;
	logic [LEN_W-1:0] len_q;
	logic             valid_s1;
	cmd_word_t        word_s1;
	logic             rsp_valid_q;
	rsp_word_t        rsp_word_q;

	logic                  accept;
	logic                  fire;
	logic                  do_add;
	logic [LIST_DEPTH-1:0] hit;
	logic [LIST_DEPTH-1:0] upto;
	logic [LIST_DEPTH-1:0] load;
	logic [15:0]           ids   [LIST_DEPTH];
	logic [31:0]           names [LIST_DEPTH];
	pick_t                 pick;

	logic [CMP_W-1:0] len_w;
	logic [CMP_W-1:0] lim;
	logic [CMP_W-1:0] grown;
	logic [CMP_W-1:0] len_next;
	logic [15:0]      id1_next;
	rsp_word_t        rsp_next;

	assign cmd_stall = valid_s1;
	assign accept    = cmd_valid && !valid_s1;
	assign fire      = valid_s1 && !(rsp_valid_q && rsp_stall);
	assign do_add    = fire && (word_s1.command == CMD_ADD);

	for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
		logic [15:0] din_id;
		logic [31:0] din_name;
		if (k == 0) begin : g_front
			assign din_id   = word_s1.cmd_id;
			assign din_name = word_s1.name_tag;
			assign load[k]  = do_add;
		end else begin : g_back
			assign din_id   = ids[k-1];
			assign din_name = names[k-1];
			assign load[k]  = do_add && (pick.any ? upto[k] : (LEN_W'(k) <= len_q));
		end
		mcl_cell #(
			.INDEX (k),
			.LEN_W (LEN_W)
		) u_cell (
			.clk      (clk),
			.capture  (accept),
			.word     (cmd_word),
			.length   (len_q),
			.load     (load[k]),
			.din_id   (din_id),
			.din_name (din_name),
			.hit      (hit[k]),
			.id       (ids[k]),
			.name     (names[k])
		);
	end

	mcl_pick #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_pick (
		.hit   (hit),
		.ids   (ids),
		.names (names),
		.upto  (upto),
		.pick  (pick)
	);

	always_comb begin
		len_w = CMP_W'(len_q);
		priority if (max_q == 6'd0) begin
			lim = CMP_W'(1);
		end else if (CMP_W'(max_q) > CMP_W'(LIST_DEPTH)) begin
			lim = CMP_W'(LIST_DEPTH);
		end else begin
			lim = CMP_W'(max_q);
		end
		priority if (pick.any || len_w >= CMP_W'(LIST_DEPTH)) begin
			grown = len_w;
		end else begin
			grown = len_w + CMP_W'(1);
		end
		if (word_s1.command == CMD_ADD) begin
			len_next = (grown > lim) ? lim : grown;
			id1_next = load[1] ? ids[0] : ids[1];
		end else begin
			len_next = len_w;
			id1_next = ids[1];
		end
		rsp_next.found          = pick.any;
		rsp_next.out_id         = '0;
		rsp_next.out_name       = '0;
		if (pick.any) begin
			if (word_s1.command == CMD_ADD) begin
				rsp_next.out_id   = word_s1.cmd_id;
				rsp_next.out_name = word_s1.name_tag;
			end else begin
				rsp_next.out_id   = pick.sel_id;
				rsp_next.out_name = pick.sel_name;
			end
		end
		rsp_next.entry_count    = len_next[5:0];
		rsp_next.previous_valid = len_next >= CMP_W'(2);
		rsp_next.previous_id    = rsp_next.previous_valid ? id1_next : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q       <= MAX_ENTRIES_RST;
			len_q       <= '0;
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_data;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				len_q       <= len_next[LEN_W-1:0];
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= cmd_word;
		end
		if (fire) begin
			rsp_word_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(len_q) <= LIST_DEPTH)
		else $error("list length beyond depth");

	a_add_unique: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && word_s1.command == CMD_ADD |-> $onehot0(hit))
		else $error("id present twice in list");

	a_accept_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1 && !cmd_stall == 1'b0)
		else $error("accepted word not held in first step");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_word_q.found |-> rsp_word_q.out_id == 16'd0
			&& rsp_word_q.out_name == 32'd0)
		else $error("miss response carries entry data");

	a_prev_flag: assert property (@(posedge clk) disable iff (!arst_n)
		$past(fire) |-> rsp_word_q.previous_valid == (rsp_word_q.entry_count >= 6'd2))
		else $error("previous flag disagrees with count");

endmodule

### sim/mru_command_list_core_tb.sv
// mru_command_list_core_tb: self-checking testbench of the mru command list core
// drives directed and random command words under several list limits, checks each response
// depends on mcl_pkg and mru_command_list_core
`timescale 1ns / 1ps

module mru_command_list_core_tb;
	import mcl_pkg::*;

	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 113;
	localparam int LONG_HOLD = 200;

	class mru_tracker;
		logic [15:0] ids [LIST_DEPTH_DEF];
		logic [31:0] names [LIST_DEPTH_DEF];
		int unsigned len;
		logic [5:0] max_entries;
		rsp_word_t rsp_due [$];
		int errors;

		function void clear();
			len = 0;
			max_entries = MAX_ENTRIES_RST;
			errors = 0;
			rsp_due.delete();
			foreach (ids[i]) begin
				ids[i] = '0;
				names[i] = '0;
			end
		endfunction

		function void set_limit(logic [5:0] v);
			max_entries = v;
		endfunction

		function int unsigned keep_limit();
			if (max_entries == 0)
				return 1;
			if (max_entries > LIST_DEPTH_DEF)
				return LIST_DEPTH_DEF;
			return max_entries;
		endfunction

		function void push_front(int unsigned upto, logic [15:0] id, logic [31:0] name);
			for (int k = upto; k > 0; k--) begin
				ids[k] = ids[k - 1];
				names[k] = names[k - 1];
			end
			ids[0] = id;
			names[0] = name;
		endfunction

		function int pending();
			return rsp_due.size();
		endfunction

		function void take_command(cmd_word_t w);
			rsp_word_t r;
			int unsigned pos;
			int unsigned upto;
			r = '0;
			case (w.command)
				CMD_ADD: begin
					pos = len;
					for (int i = 0; i < len; i++)
						if (pos == len && ids[i] == w.cmd_id)
							pos = i;
					if (pos < len) begin
						push_front(pos, w.cmd_id, w.name_tag);
						r.found = 1'b1;
						r.out_id = w.cmd_id;
						r.out_name = w.name_tag;
					end else begin
						upto = (len >= LIST_DEPTH_DEF) ? LIST_DEPTH_DEF - 1 : len;
						push_front(upto, w.cmd_id, w.name_tag);
						len = upto + 1;
					end
					if (len > keep_limit())
						len = keep_limit();
				end
				CMD_FIND: begin
					for (int i = 0; i < len; i++)
						if (!r.found && names[i] == w.name_tag) begin
							r.found = 1'b1;
							r.out_id = ids[i];
							r.out_name = names[i];
						end
				end
				CMD_READ: begin
					if (w.read_index < len) begin
						r.found = 1'b1;
						r.out_id = ids[w.read_index];
						r.out_name = names[w.read_index];
					end
				end
				default: begin
				end
			endcase
			r.entry_count = 6'(len);
			r.previous_valid = (len >= 2);
			r.previous_id = (len >= 2) ? ids[1] : '0;
			rsp_due.push_back(r);
		endfunction

		function void check_field(string fname, logic [31:0] exp_v, logic [31:0] got_v);
			if (got_v !== exp_v) begin
				$display("%0t mismatch %s expected %h actual %h", $time, fname, exp_v, got_v);
				errors++;
			end
		endfunction

		function void match_response(rsp_word_t got);
			rsp_word_t exp_w;
			if (rsp_due.size() == 0) begin
				$display("%0t response word with none due expected none actual %h", $time, got);
				errors++;
				return;
			end
			exp_w = rsp_due.pop_front();
			check_field("found", exp_w.found, got.found);
			check_field("out_id", exp_w.out_id, got.out_id);
			check_field("out_name", exp_w.out_name, got.out_name);
			check_field("entry_count", exp_w.entry_count, got.entry_count);
			check_field("previous_valid", exp_w.previous_valid, got.previous_valid);
			check_field("previous_id", exp_w.previous_id, got.previous_id);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [5:0] cfg_data;
	logic cmd_valid;
	logic cmd_stall;
	cmd_word_t cmd_word;
	logic rsp_valid;
	logic rsp_stall;
	rsp_word_t rsp_word;

	bit idle_on;
	bit long_hold_req;
	int cycles;
	cmd_word_t plan [$];
	mru_tracker sb = new;

	mru_command_list_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_word (cmd_word),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_word (rsp_word)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic int gap_length();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic cmd_word_t mk(logic [1:0] c, logic [15:0] id, logic [31:0] name,
		logic [4:0] idx);
		cmd_word_t w;
		w.command = c;
		w.cmd_id = id;
		w.name_tag = name;
		w.read_index = idx;
		return w;
	endfunction

	function automatic cmd_word_t pick_cmd(int add_pct);
		cmd_word_t w;
		int roll;
		int unsigned top;
		roll = $urandom_range(0, 9);
		if ($urandom_range(0, 99) < add_pct)
			w.command = CMD_ADD;
		else if (roll < 4)
			w.command = CMD_FIND;
		else if (roll < 8)
			w.command = CMD_READ;
		else
			w.command = CMD_NOP;
		roll = $urandom_range(0, 9);
		if (roll < 4)
			w.cmd_id = 16'($urandom_range(0, 39));
		else if (roll < 6 && sb.len > 0)
			w.cmd_id = sb.ids[$urandom_range(0, sb.len - 1)];
		else
			w.cmd_id = 16'($urandom());
		if ($urandom_range(0, 1) == 0 && sb.len > 0)
			w.name_tag = sb.names[$urandom_range(0, sb.len - 1)];
		else
			w.name_tag = $urandom();
		top = (sb.len + 2 > 31) ? 31 : sb.len + 2;
		if ($urandom_range(0, 9) < 7)
			w.read_index = 5'($urandom_range(0, top));
		else
			w.read_index = 5'($urandom_range(0, 31));
		return w;
	endfunction

	task automatic send_cmd(input cmd_word_t w);
		cmd_word <= w;
		cmd_valid <= 1'b1;
		do
			@(posedge clk);
		while (!(cmd_valid && !cmd_stall));
		sb.take_command(w);
	endtask

	task automatic sender_gap();
		int n;
		if (!idle_on || $urandom_range(0, 3) != 0)
			return;
		n = gap_length();
		cmd_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic run_items(int n, int add_pct);
		cmd_word_t w;
		for (int i = 0; i < n; i++) begin
			w = (plan.size() > 0) ? plan.pop_front() : pick_cmd(add_pct);
			send_cmd(w);
			if (i == n - 1)
				cmd_valid <= 1'b0;
			else
				sender_gap();
		end
	endtask

	task automatic wait_idle(int settle);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_limit(logic [5:0] v);
		cfg_we <= 1'b1;
		cfg_data <= v;
		sb.set_limit(v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : rsp_side
		int stall_left;
		stall_left = 0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall)
				sb.match_response(rsp_word);
			if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = LONG_HOLD - 1;
				rsp_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				stall_left = gap_length() - 1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		logic [5:0] phase_limit [PHASES];
		phase_limit = '{6'd32, 6'd63, 6'd5, 6'd1, 6'd0, 6'd20, 6'd33, 6'd2, 6'd0, 6'd32};
		phase_limit[8] = 6'($urandom_range(0, 63));
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_data <= '0;
		cmd_valid <= 1'b0;
		cmd_word <= '0;
		idle_on = 1'b1;
		long_hold_req = 1'b0;
		cycles = 0;
		sb.clear();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list, misses, hit with move to front, field extremes
		plan.push_back(mk(CMD_READ, 16'h0000, 32'h0000_0000, 5'd0));
		plan.push_back(mk(CMD_FIND, 16'h0000, 32'h0000_0000, 5'd0));
		plan.push_back(mk(CMD_NOP, 16'hFFFF, 32'hFFFF_FFFF, 5'd31));
		plan.push_back(mk(CMD_ADD, 16'h0000, 32'h0000_0000, 5'd0));
		plan.push_back(mk(CMD_ADD, 16'hFFFF, 32'hFFFF_FFFF, 5'd31));
		plan.push_back(mk(CMD_ADD, 16'h1234, 32'hA5A5_A5A5, 5'd0));
		plan.push_back(mk(CMD_ADD, 16'h0000, 32'h5A5A_5A5A, 5'd0));
		plan.push_back(mk(CMD_FIND, 16'h0000, 32'hFFFF_FFFF, 5'd0));
		plan.push_back(mk(CMD_FIND, 16'hFFFF, 32'h0000_0000, 5'd0));
		plan.push_back(mk(CMD_READ, 16'h0000, 32'h0000_0000, 5'd0));
		plan.push_back(mk(CMD_READ, 16'h0000, 32'h0000_0000, 5'd2));
		plan.push_back(mk(CMD_READ, 16'h0000, 32'h0000_0000, 5'd3));
		plan.push_back(mk(CMD_READ, 16'hFFFF, 32'hFFFF_FFFF, 5'd31));
		plan.push_back(mk(CMD_NOP, 16'h0000, 32'h0000_0000, 5'd0));
		run_items(plan.size(), 0);
		wait_idle(4);
		// lowered limit trims on the next add
		write_limit(6'd2);
		plan.push_back(mk(CMD_ADD, 16'h00AA, 32'h1111_1111, 5'd0));
		plan.push_back(mk(CMD_READ, 16'h0000, 32'h0000_0000, 5'd2));
		run_items(plan.size(), 0);
		wait_idle(4);
		// zero limit keeps one entry
		write_limit(6'd0);
		plan.push_back(mk(CMD_ADD, 16'h00BB, 32'h2222_2222, 5'd0));
		plan.push_back(mk(CMD_READ, 16'h0000, 32'h0000_0000, 5'd0));
		plan.push_back(mk(CMD_READ, 16'h0000, 32'h0000_0000, 5'd1));
		run_items(plan.size(), 0);
		wait_idle(4);

		for (int p = 0; p < PHASES; p++) begin
			write_limit(phase_limit[p]);
			idle_on = !(p == 2 || p == 3 || p == 6);
			if (p == 3)
				long_hold_req = 1'b1;
			run_items(PHASE_ITEMS, (p == 0) ? 70 : 45);
			wait_idle(4);
		end

		wait_idle(12);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
